[hdl/sos_pkg.sv]
package sos_pkg;

   // Orbit value width and the word width of the seed, value and residue fields.
   localparam int VALUE_WIDTH = 128;
   localparam int WORD_WIDTH = 64;
   localparam int HALV_WIDTH = 7;

   // The sum 3v+1 needs two bits of headroom above the orbit value.
   localparam int TRIPLE_WIDTH = VALUE_WIDTH + 2;

   // Trailing zeros are stripped one byte at a time.
   localparam int STRIP_CHUNK = 8;
   localparam int STRIP_SHIFT_WIDTH = $clog2(STRIP_CHUNK);

   // The remainder unit handles one dividend bit per cycle.
   localparam int MOD_COUNT_WIDTH = $clog2(VALUE_WIDTH);

   // Register file: one 64-bit register every eight bytes.
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 64;
   localparam int CSR_INDEX_LSB = 3;
   localparam logic REG_RESIDUE_MODULUS = 1'b0;
   localparam logic [CSR_DATA_WIDTH-1:0] RESIDUE_MODULUS_RESET = CSR_DATA_WIDTH'(1);

   // Command codes.
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_STRIP,
      SEQ_RESIDUE
   } seq_state_type;

   // Commands from the sequencer to the orbit unit; at most one is set.
   typedef struct packed {
      logic load;
      logic add;
      logic strip;
   } orbit_ctrl_type;

   typedef struct packed {
      logic stripping;
      logic overflowed;
   } orbit_status_type;

   // Number of trailing zeros of a nonzero chunk.
   function automatic logic [STRIP_SHIFT_WIDTH-1:0] chunk_zeros(
      input logic [STRIP_CHUNK-1:0] chunk);
      logic [STRIP_SHIFT_WIDTH-1:0] count;
      count = '0;
      for (int i = STRIP_CHUNK - 1; i >= 0; i--) begin
         if (chunk[i]) begin
            count = STRIP_SHIFT_WIDTH'(i);
         end
      end
      return count;
   endfunction

endpackage

[hdl/sos_req_if.sv]
interface sos_req_if;
   logic                           valid;
   logic                           ready;
   logic                           command;
   logic [sos_pkg::WORD_WIDTH-1:0] seed;

   modport source (output valid, output command, output seed, input ready);
   modport sink (input valid, input command, input seed, output ready);
endinterface

[hdl/sos_rsp_if.sv]
interface sos_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [sos_pkg::HALV_WIDTH-1:0] halvings;
   logic                           overflowed;
   logic                           reached_one;
   logic [sos_pkg::WORD_WIDTH-1:0] residue;
   logic [sos_pkg::WORD_WIDTH-1:0] value_low;
   logic [sos_pkg::WORD_WIDTH-1:0] value_high;

   modport source (output valid, output halvings, output overflowed, output reached_one,
                   output residue, output value_low, output value_high, input ready);
   modport sink (input valid, input halvings, input overflowed, input reached_one,
                 input residue, input value_low, input value_high, output ready);
endinterface

[hdl/syracuse_orbit_stepper.sv]
// Channel  | Direction | Beat contents
// ---------+-----------+-----------------------------------------------------
// req_bus  | in        | command, seed
// rsp_bus  | out       | halvings, overflowed, reached_one, residue, value_low,
//          |           | value_high
// csr_*    | in/out    | APB register file: residue_modulus at byte address 0
//
// A request is accepted, then the trailing zeros of 3v+1 are stripped a byte at a time
// (a load or an overflowing step strips nothing), then the bit-serial remainder unit
// forms the residue of the orbit value. Reset is
// synchronous and active high; it clears the orbit value, the overflow flag and sets
// the modulus to one. The result sits in an output register, so a new request is taken
// while it waits; a later result holds in the sequencer until the register is free.
module syracuse_orbit_stepper (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [sos_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [sos_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [sos_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                               csr_pready,
   sos_req_if.sink                            req_bus,
   sos_rsp_if.source                          rsp_bus
);

   sos_pkg::seq_state_type           state_ff, state_in;
   sos_pkg::orbit_ctrl_type          orbit_ctrl;
   sos_pkg::orbit_status_type        orbit_status;
   logic [sos_pkg::VALUE_WIDTH-1:0]  orbit_value;
   logic [sos_pkg::HALV_WIDTH-1:0]   halvings;
   logic [sos_pkg::WORD_WIDTH-1:0]   residue_modulus;
   logic [sos_pkg::WORD_WIDTH-1:0]   residue;
   logic [2*sos_pkg::WORD_WIDTH-1:0] value_words;
   logic                             mod_start;
   logic                             mod_busy;
   logic                             req_ready;
   logic                             out_load;
   logic                             slot_free;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [sos_pkg::HALV_WIDTH-1:0]   halvings_ff;
   logic                             overflowed_ff;
   logic                             reached_one_ff;
   logic [sos_pkg::WORD_WIDTH-1:0]   residue_ff;
   logic [sos_pkg::WORD_WIDTH-1:0]   value_low_ff;
   logic [sos_pkg::WORD_WIDTH-1:0]   value_high_ff;

   sos_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .residue_modulus (residue_modulus)
   );

   sos_orbit_unit u_orbit (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (orbit_ctrl),
      .seed        (req_bus.seed),
      .status      (orbit_status),
      .orbit_value (orbit_value),
      .halvings    (halvings)
   );

   sos_mod_unit u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (orbit_value),
      .modulus  (residue_modulus),
      .busy     (mod_busy),
      .residue  (residue)
   );

   assign slot_free = !rsp_valid_ff || rsp_bus.ready;

   // Sequencer: accept, strip, then run the remainder and hand the beat over.
   always_comb begin
      state_in = state_ff;
      orbit_ctrl = '0;
      mod_start = 1'b0;
      out_load = 1'b0;
      req_ready = 1'b0;
      unique case (state_ff)
         sos_pkg::SEQ_IDLE: begin
            req_ready = 1'b1;
            if (req_bus.valid) begin
               if (req_bus.command == sos_pkg::CMD_LOAD) begin
                  orbit_ctrl.load = 1'b1;
               end else begin
                  orbit_ctrl.add = 1'b1;
               end
               state_in = sos_pkg::SEQ_STRIP;
            end
         end
         sos_pkg::SEQ_STRIP: begin
            if (orbit_status.stripping) begin
               orbit_ctrl.strip = 1'b1;
            end else begin
               mod_start = 1'b1;
               state_in = sos_pkg::SEQ_RESIDUE;
            end
         end
         sos_pkg::SEQ_RESIDUE: begin
            if (!mod_busy && slot_free) begin
               out_load = 1'b1;
               state_in = sos_pkg::SEQ_IDLE;
            end
         end
         default: begin
            state_in = sos_pkg::SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sos_pkg::SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Output register for the result beat.
   assign value_words = (2*sos_pkg::WORD_WIDTH)'(orbit_value);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         halvings_ff <= halvings;
         overflowed_ff <= orbit_status.overflowed;
         reached_one_ff <= (orbit_value == sos_pkg::VALUE_WIDTH'(1));
         residue_ff <= residue;
         value_low_ff <= value_words[sos_pkg::WORD_WIDTH-1:0];
         value_high_ff <= value_words[2*sos_pkg::WORD_WIDTH-1:sos_pkg::WORD_WIDTH];
      end
   end

   assign req_bus.ready = req_ready;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.halvings = halvings_ff;
   assign rsp_bus.overflowed = overflowed_ff;
   assign rsp_bus.reached_one = reached_one_ff;
   assign rsp_bus.residue = residue_ff;
   assign rsp_bus.value_low = value_low_ff;
   assign rsp_bus.value_high = value_high_ff;

endmodule

[hdl/sos_csr.sv]
module sos_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [sos_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [sos_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [sos_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                               csr_pready,
   output logic [sos_pkg::WORD_WIDTH-1:0]     residue_modulus
);

   logic [sos_pkg::WORD_WIDTH-1:0] modulus_ff;
   logic [sos_pkg::WORD_WIDTH-1:0] modulus_in;
   logic                           index_hit;

   // Only the register at index zero exists; other addresses read as zero.
   assign index_hit = (csr_paddr[sos_pkg::CSR_INDEX_LSB] == sos_pkg::REG_RESIDUE_MODULUS);

   always_comb begin
      modulus_in = modulus_ff;
      if (csr_psel && csr_penable && csr_pwrite && index_hit) begin
         modulus_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= sos_pkg::RESIDUE_MODULUS_RESET;
      end else begin
         modulus_ff <= modulus_in;
      end
   end

   assign csr_prdata = index_hit ? modulus_ff : '0;
   assign csr_pready = 1'b1;
   assign residue_modulus = modulus_ff;

endmodule

[hdl/sos_orbit_unit.sv]
module sos_orbit_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  sos_pkg::orbit_ctrl_type          ctrl,
   input  logic [sos_pkg::WORD_WIDTH-1:0]   seed,
   output sos_pkg::orbit_status_type        status,
   output logic [sos_pkg::VALUE_WIDTH-1:0]  orbit_value,
   output logic [sos_pkg::HALV_WIDTH-1:0]   halvings
);

   logic [sos_pkg::VALUE_WIDTH-1:0]       orbit_ff, orbit_in;
   logic [sos_pkg::VALUE_WIDTH-1:0]       work_ff, work_in;
   logic [sos_pkg::HALV_WIDTH-1:0]        halv_ff, halv_in;
   logic                                  overflow_ff, overflow_in;
   logic                                  stripping_ff, stripping_in;
   logic [sos_pkg::TRIPLE_WIDTH-1:0]      triple;
   logic                                  triple_fits;
   logic [sos_pkg::STRIP_SHIFT_WIDTH-1:0] low_zeros;

   // 3v+1 as 2v + v + 1, with headroom to see whether it leaves the value range.
   assign triple = sos_pkg::TRIPLE_WIDTH'({orbit_ff, 1'b0})
                 + sos_pkg::TRIPLE_WIDTH'(orbit_ff)
                 + sos_pkg::TRIPLE_WIDTH'(1);
   assign triple_fits = (triple[sos_pkg::TRIPLE_WIDTH-1:sos_pkg::VALUE_WIDTH] == '0);
   assign low_zeros = sos_pkg::chunk_zeros(work_ff[sos_pkg::STRIP_CHUNK-1:0]);

   // Load, form 3v+1, then strip trailing zeros a byte per cycle until the
   // lowest byte holds a one; the final partial shift lands in the orbit value.
   always_comb begin
      orbit_in = orbit_ff;
      work_in = work_ff;
      halv_in = halv_ff;
      overflow_in = overflow_ff;
      stripping_in = stripping_ff;
      priority if (ctrl.load) begin
         orbit_in = sos_pkg::VALUE_WIDTH'(seed);
         overflow_in = 1'b0;
         halv_in = '0;
         stripping_in = 1'b0;
      end else if (ctrl.add) begin
         halv_in = '0;
         if (!overflow_ff) begin
            if (triple_fits) begin
               work_in = triple[sos_pkg::VALUE_WIDTH-1:0];
               stripping_in = 1'b1;
            end else begin
               overflow_in = 1'b1;
            end
         end
      end else if (ctrl.strip) begin
         if (work_ff[sos_pkg::STRIP_CHUNK-1:0] == '0) begin
            work_in = work_ff >> sos_pkg::STRIP_CHUNK;
            halv_in = halv_ff + sos_pkg::HALV_WIDTH'(sos_pkg::STRIP_CHUNK);
         end else begin
            orbit_in = work_ff >> low_zeros;
            halv_in = halv_ff + sos_pkg::HALV_WIDTH'(low_zeros);
            stripping_in = 1'b0;
         end
      end else begin
         stripping_in = stripping_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         orbit_ff <= '0;
         overflow_ff <= 1'b0;
         stripping_ff <= 1'b0;
         halv_ff <= '0;
      end else begin
         orbit_ff <= orbit_in;
         overflow_ff <= overflow_in;
         stripping_ff <= stripping_in;
         halv_ff <= halv_in;
      end
   end

   // The working copy needs no reset: it is always written before it is used.
   always_ff @(posedge clock) begin
      work_ff <= work_in;
   end

   assign status.stripping = stripping_ff;
   assign status.overflowed = overflow_ff;
   assign orbit_value = orbit_ff;
   assign halvings = halv_ff;

endmodule

[hdl/sos_mod_unit.sv]
module sos_mod_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [sos_pkg::VALUE_WIDTH-1:0] dividend,
   input  logic [sos_pkg::WORD_WIDTH-1:0]  modulus,
   output logic                            busy,
   output logic [sos_pkg::WORD_WIDTH-1:0]  residue
);

   logic [sos_pkg::WORD_WIDTH-1:0]      rem_ff, rem_in;
   logic [sos_pkg::VALUE_WIDTH-1:0]     shift_ff, shift_in;
   logic [sos_pkg::MOD_COUNT_WIDTH-1:0] count_ff, count_in;
   logic                                busy_ff, busy_in;
   logic [sos_pkg::WORD_WIDTH:0]        trial;
   logic [sos_pkg::WORD_WIDTH:0]        diff;
   logic                                take;

   // Shift the next dividend bit into the partial remainder and subtract the
   // modulus when it fits; the extra top bit covers a remainder at 2^63 or above.
   assign trial = {rem_ff, shift_ff[sos_pkg::VALUE_WIDTH-1]};
   assign diff = trial - {1'b0, modulus};
   assign take = (trial >= {1'b0, modulus});

   always_comb begin
      rem_in = rem_ff;
      shift_in = shift_ff;
      count_in = count_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in = '0;
         shift_in = dividend;
         count_in = sos_pkg::MOD_COUNT_WIDTH'(sos_pkg::VALUE_WIDTH - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = take ? diff[sos_pkg::WORD_WIDTH-1:0] : trial[sos_pkg::WORD_WIDTH-1:0];
         shift_in = shift_ff << 1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      shift_ff <= shift_in;
      count_ff <= count_in;
   end

   // A zero modulus reports a zero residue.
   assign residue = (modulus == '0) ? '0 : rem_ff;
   assign busy = busy_ff;

endmodule

[hdl/sos_checker.sv]
module sos_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [sos_pkg::HALV_WIDTH-1:0] rsp_halvings,
   input logic                           rsp_overflowed,
   input logic [sos_pkg::WORD_WIDTH-1:0] rsp_value_low
);

   // Once a request is taken the block is busy for the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while a previous one was in progress");

   // A result beat stays offered until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result beat withdrawn before it was taken");

   // A step that stripped bits cannot also have overflowed.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_halvings != '0)) |-> !rsp_overflowed)
      else $error("halvings reported together with overflow");

   // After stripping, the stored orbit value is odd.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_halvings != '0)) |-> rsp_value_low[0])
      else $error("stripped orbit value is even");

   // Reset leaves no result beat on offer.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat offered right after reset");

endmodule

bind syracuse_orbit_stepper sos_checker u_sos_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_halvings   (rsp_bus.halvings),
   .rsp_overflowed (rsp_bus.overflowed),
   .rsp_value_low  (rsp_bus.value_low)
);
